// ----- hw/rtl/sdg_pkg.sv -----
// ----------------------------------------------------------------------------
// sdg_pkg
// Shared types, register indexes and constants for the sidechain ducker
// gain core.
// ----------------------------------------------------------------------------
package sdg_pkg;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE, ST_SQ, ST_MSD, ST_MLO, ST_MHI, ST_MUPD, ST_NORM, ST_LSQ, ST_LUPD,
    ST_LDB, ST_LEV, ST_TGT, ST_KNEE, ST_DLOAD, ST_DIV, ST_CLAMP, ST_ENV,
    ST_EUPD, ST_GAIN, ST_GX, ST_GMUL, ST_GUPD, ST_GFIN
  } state_t;

  // configuration register indexes
  localparam logic [2:0] CFG_ENABLED       = 3'd0;
  localparam logic [2:0] CFG_THRESHOLD_DB  = 3'd1;
  localparam logic [2:0] CFG_DEPTH_DB      = 3'd2;
  localparam logic [2:0] CFG_ATTACK_COEFF  = 3'd3;
  localparam logic [2:0] CFG_RELEASE_COEFF = 3'd4;
  localparam logic [2:0] CFG_HOLD_SAMPLES  = 3'd5;
  localparam logic [2:0] CFG_RMS_COEFF     = 3'd6;
  localparam logic [2:0] CFG_DISABLE_COEFF = 3'd7;

  // shared multiplier operand width
  localparam int MUL_W = 32;

  // level floor for silence, -200 dB in Q8.8
  localparam logic signed [17:0] FLOOR_DB_Q8 = -18'sd51200;
  // 10*log10(2) in Q16.16
  localparam logic [31:0] DB_PER_LOG2_Q16 = 32'd197283;
  // log2(10)/20 in Q0.24
  localparam logic [31:0] LOG2_PER_DB_Q24 = 32'd2786635;
  // full scale of the mean square, 46 in Q6.16
  localparam logic [21:0] LOG2_FULL_SCALE = 22'd3014656;

  // gain factors 2^(-2^(k-16)) in Q1.30, one per fraction bit
  typedef logic [15:0][31:0] fact_tab_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] rem;
    r   = '0;
    b   = 64'h4000_0000_0000_0000;
    rem = v;
    for (int i = 0; i < 32; i++) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r   = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic fact_tab_t build_fact_tab();
    fact_tab_t   t;
    logic [63:0] c;
    c = 64'd1 << 29;
    for (int k = 15; k >= 0; k--) begin
      c    = isqrt64(c << 30);
      t[k] = c[31:0];
    end
    return t;
  endfunction

endpackage

// ----- hw/rtl/sidechain_ducker_gain_core.sv -----
// A request runs as a sequence of steps on the shared 32x32 multiplier, with
// shorter paths when disabled or with a silent detector: bit normalization,
// a squaring step per bit in the log2 loop, the reciprocal divide of the knee
// and above-knee regions, and a multiply step per bit in the gain loop.
// Throughput: one request at a time, the next taken as the result becomes valid;
// a stalled result holds the sequencer. Reset: synchronous, restores defaults.
// ----------------------------------------------------------------------------
// sidechain_ducker_gain_core
// Soft-knee ducking gain computer with mean-square detector and
// attack/hold/release ballistics, run on one shared multiplier.
// ----------------------------------------------------------------------------
module sidechain_ducker_gain_core #(
  parameter int KNEE_DB_Q8 = 1536,
  parameter int RATIO      = 20
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] key_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        gain,
  output logic [13:0]        reduction_db,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [19:0]        cfg_data
);
  import sdg_pkg::*;

  // reciprocal divide constants: shift 31+clog2(d) keeps the reciprocal in 32 bits
  localparam int                 SH_ABOVE  = 31 + $clog2(RATIO);
  localparam int                 SH_KNEE   = 31 + $clog2(KNEE_DB_Q8 * RATIO);
  localparam logic [MUL_W-1:0]   DEN_ABOVE = MUL_W'(RATIO);
  localparam logic [MUL_W-1:0]   DEN_KNEE  = MUL_W'(KNEE_DB_Q8 * RATIO);
  localparam logic [MUL_W-1:0]   RCP_ABOVE = MUL_W'((64'd1 << SH_ABOVE) / 64'(RATIO));
  localparam logic [MUL_W-1:0]   RCP_KNEE  =
    MUL_W'((64'd1 << SH_KNEE) / 64'(KNEE_DB_Q8 * RATIO));
  localparam logic [5:0]         QSH_ABOVE = 6'(SH_ABOVE);
  localparam logic [5:0]         QSH_KNEE  = 6'(SH_KNEE);
  localparam logic [MUL_W-1:0]   RATIO_M1  = MUL_W'(RATIO - 1);
  localparam logic signed [20:0] KNEE_POS  = 21'(KNEE_DB_Q8);
  localparam logic signed [20:0] KNEE_NEG  = -21'(KNEE_DB_Q8);
  localparam fact_tab_t          FACT      = build_fact_tab();

  // configuration
  logic               enabled;
  logic signed [14:0] threshold_db;
  logic [13:0]        depth_db;
  logic [15:0]        attack_coeff;
  logic [15:0]        release_coeff;
  logic [19:0]        hold_samples;
  logic [15:0]        rms_coeff;
  logic [15:0]        disable_coeff;

  // state and datapath
  state_t             state, state_next;
  logic [47:0]        ms;
  logic [13:0]        env;
  logic [19:0]        hold_cnt;
  logic [23:0]        abs_key;
  logic [47:0]        diff;
  logic               dir_up;
  logic [39:0]        acc;
  logic [47:0]        norm_m;
  logic [5:0]         top_pos;
  logic [30:0]        mant;
  logic [15:0]        frac;
  logic [3:0]         step_cnt;
  logic signed [17:0] level;
  logic [13:0]        tgt;
  logic [MUL_W-1:0]   num;
  logic [MUL_W-1:0]   quo;
  logic               div_above;
  logic               env_dir;
  logic [3:0]         gx_n;
  logic [15:0]        gx_f;
  logic [30:0]        gr;

  // multiplier
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] prod;

  sdg_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // mean-square one-pole step
  logic        sq_ge;
  logic [63:0] ms_step64;
  logic [47:0] ms_next;
  assign sq_ge     = prod[47:0] >= ms;
  assign ms_step64 = {prod[39:0], 24'd0} + {24'd0, acc} + 64'd65535;
  assign ms_next   = dir_up ? ms + ms_step64[63:16] : ms - ms_step64[63:16];

  // log2 squaring and dB scaling
  logic [31:0] log_t;
  logic [40:0] lev_sum;
  logic [21:0] log_mag;
  assign log_t   = prod[61:30];
  assign lev_sum = prod[40:0] + 41'd8388608;
  assign log_mag = LOG2_FULL_SCALE - {top_pos[5:0], frac};

  // gain computer
  logic signed [19:0] over;
  logic signed [20:0] over2;
  logic signed [20:0] knee_u;
  logic               is_below, is_above;
  assign over     = 20'(level) - 20'(threshold_db);
  assign over2    = {over, 1'b0};
  assign knee_u   = over2 + KNEE_POS;
  assign is_below = over2 <= KNEE_NEG;
  assign is_above = over2 >= KNEE_POS;

  // divide by a constant: reciprocal estimate, then one correction step
  logic [MUL_W-1:0]   div_den;
  logic [MUL_W-1:0]   div_rcp;
  logic [5:0]         div_sh;
  logic [MUL_W-1:0]   div_n;
  logic [2*MUL_W-1:0] q_est_w;
  logic [MUL_W-1:0]   q_est;
  logic [MUL_W-1:0]   div_rem;
  logic [MUL_W-1:0]   q_fix;
  assign div_den = div_above ? DEN_ABOVE : DEN_KNEE;
  assign div_rcp = div_above ? RCP_ABOVE : RCP_KNEE;
  assign div_sh  = div_above ? QSH_ABOVE : QSH_KNEE;
  // knee numerator carries the factor 8 of its divisor as a shift
  assign div_n   = div_above ? prod[MUL_W-1:0] : prod[MUL_W+2:3];
  assign q_est_w = prod >> div_sh;
  assign q_est   = q_est_w[MUL_W-1:0];
  assign div_rem = num - prod[MUL_W-1:0];
  assign q_fix   = (div_rem >= div_den) ? quo + MUL_W'(1) : quo;

  // envelope ballistics
  logic        env_up, env_hold;
  logic [15:0] env_coeff;
  logic [13:0] env_diff;
  logic [30:0] env_sum;
  assign env_up   = tgt > env;
  assign env_hold = enabled && !env_up && (hold_cnt != '0);
  assign env_diff = env_up ? tgt - env : env - tgt;
  assign env_sum  = {1'b0, prod[29:0]} + 31'd65535;

  always_comb begin
    if (!enabled) begin
      env_coeff = disable_coeff;
    end else if (env_up) begin
      env_coeff = attack_coeff;
    end else begin
      env_coeff = release_coeff;
    end
  end

  // gain conversion
  logic [35:0] gx_sum;
  logic [4:0]  gain_sh;
  logic [31:0] gain_rnd;
  logic [31:0] gain_val;
  assign gx_sum   = prod[35:0] + 36'd32768;
  assign gain_sh  = 5'd15 + {1'b0, gx_n};
  assign gain_rnd = {1'b0, gr} + (32'd1 << (gain_sh - 5'd1));
  assign gain_val = gain_rnd >> gain_sh;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_SQ;
      ST_SQ:    state_next = ST_MSD;
      ST_MSD:   state_next = ST_MLO;
      ST_MLO:   state_next = ST_MHI;
      ST_MHI:   state_next = ST_MUPD;
      ST_MUPD: begin
        if (!enabled) begin
          state_next = ST_ENV;
        end else if (ms_next == '0) begin
          state_next = ST_TGT;
        end else begin
          state_next = ST_NORM;
        end
      end
      ST_NORM:  if (norm_m[47]) state_next = ST_LSQ;
      ST_LSQ:   state_next = ST_LUPD;
      ST_LUPD:  state_next = (step_cnt == '0) ? ST_LDB : ST_LSQ;
      ST_LDB:   state_next = ST_LEV;
      ST_LEV:   state_next = ST_TGT;
      ST_TGT: begin
        if (is_below) begin
          state_next = ST_ENV;
        end else if (is_above) begin
          state_next = ST_DLOAD;
        end else begin
          state_next = ST_KNEE;
        end
      end
      ST_KNEE:  state_next = ST_DLOAD;
      ST_DLOAD: state_next = ST_DIV;
      ST_DIV:   state_next = ST_CLAMP;
      ST_CLAMP: state_next = ST_ENV;
      ST_ENV:   state_next = env_hold ? ST_GAIN : ST_EUPD;
      ST_EUPD:  state_next = ST_GAIN;
      ST_GAIN:  state_next = ST_GX;
      ST_GX:    state_next = ST_GMUL;
      ST_GMUL:  state_next = ST_GUPD;
      ST_GUPD:  state_next = (step_cnt == '0) ? ST_GFIN : ST_GMUL;
      ST_GFIN:  if (!out_valid || out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer: ready and multiplier operands
  always_comb begin
    in_ready = (state == ST_IDLE);
    mul_a    = '0;
    mul_b    = '0;
    case (state)
      ST_SQ: begin
        mul_a = MUL_W'(abs_key);
        mul_b = MUL_W'(abs_key);
      end
      ST_MLO: begin
        mul_a = MUL_W'(rms_coeff);
        mul_b = MUL_W'(diff[23:0]);
      end
      ST_MHI: begin
        mul_a = MUL_W'(rms_coeff);
        mul_b = MUL_W'(diff[47:24]);
      end
      ST_LSQ: begin
        mul_a = MUL_W'(mant);
        mul_b = MUL_W'(mant);
      end
      ST_LDB: begin
        mul_a = MUL_W'(log_mag);
        mul_b = DB_PER_LOG2_Q16;
      end
      ST_TGT: begin
        if (is_above) begin
          mul_a = MUL_W'(over[16:0]);
          mul_b = RATIO_M1;
        end else begin
          mul_a = MUL_W'(knee_u[13:0]);
          mul_b = MUL_W'(knee_u[13:0]);
        end
      end
      ST_KNEE: begin
        mul_a = prod[31:0];
        mul_b = RATIO_M1;
      end
      ST_DLOAD: begin
        mul_a = div_n;
        mul_b = div_rcp;
      end
      ST_DIV: begin
        mul_a = q_est;
        mul_b = div_den;
      end
      ST_ENV: begin
        mul_a = MUL_W'(env_coeff);
        mul_b = MUL_W'(env_diff);
      end
      ST_GAIN: begin
        mul_a = MUL_W'(env);
        mul_b = LOG2_PER_DB_Q24;
      end
      ST_GMUL: begin
        mul_a = MUL_W'(gr);
        mul_b = FACT[step_cnt];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // control state, configuration and detector state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      enabled       <= 1'b1;
      threshold_db  <= -15'sd7680;
      depth_db      <= 14'd3072;
      attack_coeff  <= 16'd1000;
      release_coeff <= 16'd100;
      hold_samples  <= 20'd0;
      rms_coeff     <= 16'd200;
      disable_coeff <= 16'd500;
      ms            <= '0;
      env           <= '0;
      hold_cnt      <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      // register writes
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_ENABLED:       enabled       <= cfg_data[0];
          CFG_THRESHOLD_DB:  threshold_db  <= cfg_data[14:0];
          CFG_DEPTH_DB:      depth_db      <= cfg_data[13:0];
          CFG_ATTACK_COEFF:  attack_coeff  <= cfg_data[15:0];
          CFG_RELEASE_COEFF: release_coeff <= cfg_data[15:0];
          CFG_HOLD_SAMPLES:  hold_samples  <= cfg_data[19:0];
          CFG_RMS_COEFF:     rms_coeff     <= cfg_data[15:0];
          CFG_DISABLE_COEFF: disable_coeff <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (state == ST_MUPD) begin
        ms <= ms_next;
      end
      // hold counter and envelope
      if (state == ST_ENV) begin
        if (!enabled) begin
          hold_cnt <= '0;
        end else if (env_up) begin
          hold_cnt <= hold_samples;
        end else if (hold_cnt != '0) begin
          hold_cnt <= hold_cnt - 20'd1;
        end
      end
      if (state == ST_EUPD) begin
        env <= env_dir ? env + env_sum[29:16] : env - env_sum[29:16];
      end
      // output register
      if (state == ST_GFIN && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        abs_key <= key_sample[23] ? 24'(-key_sample) : key_sample;
      end
      ST_MSD: begin
        dir_up <= sq_ge;
        diff   <= sq_ge ? prod[47:0] - ms : ms - prod[47:0];
      end
      ST_MHI: begin
        acc <= prod[39:0];
      end
      ST_MUPD: begin
        norm_m  <= ms_next;
        top_pos <= 6'd47;
        level   <= FLOOR_DB_Q8;
        tgt     <= '0;
      end
      ST_NORM: begin
        if (norm_m[47:40] == '0) begin
          norm_m  <= norm_m << 8;
          top_pos <= top_pos - 6'd8;
        end else if (!norm_m[47]) begin
          norm_m  <= norm_m << 1;
          top_pos <= top_pos - 6'd1;
        end
        mant     <= norm_m[47:17];
        frac     <= '0;
        step_cnt <= 4'd15;
      end
      ST_LUPD: begin
        if (log_t[31]) begin
          mant            <= log_t[31:1];
          frac[step_cnt]  <= 1'b1;
        end else begin
          mant <= log_t[30:0];
        end
        step_cnt <= step_cnt - 4'd1;
      end
      ST_LEV: begin
        level <= -18'(lev_sum[40:24]);
      end
      ST_TGT: begin
        tgt       <= '0;
        div_above <= is_above;
      end
      ST_DLOAD: begin
        num <= div_n;
      end
      ST_DIV: begin
        quo <= q_est;
      end
      ST_CLAMP: begin
        tgt <= (q_fix > MUL_W'(depth_db)) ? depth_db : q_fix[13:0];
      end
      ST_ENV: begin
        env_dir <= env_up;
      end
      ST_GX: begin
        gx_n     <= gx_sum[35:32];
        gx_f     <= gx_sum[31:16];
        gr       <= 31'd1 << 30;
        step_cnt <= 4'd15;
      end
      ST_GUPD: begin
        if (gx_f[step_cnt]) begin
          gr <= prod[60:30];
        end
        step_cnt <= step_cnt - 4'd1;
      end
      ST_GFIN: begin
        if (!out_valid || out_ready) begin
          gain         <= gain_val[15:0];
          reduction_db <= env;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- hw/rtl/sdg_mul.sv -----
// ----------------------------------------------------------------------------
// sdg_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module sdg_mul (
  input  logic                     clk,
  input  logic [sdg_pkg::MUL_W-1:0] a,
  input  logic [sdg_pkg::MUL_W-1:0] b,
  output logic [2*sdg_pkg::MUL_W-1:0] prod
);
  import sdg_pkg::*;

  // product register
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// ----- hw/rtl/sdg_checker.sv -----
// ----------------------------------------------------------------------------
// sdg_checker
// Port-level checks of the ducker gain core, bound to the top level.
// ----------------------------------------------------------------------------
module sdg_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic signed [23:0] key_sample,
  input logic               out_valid,
  input logic               out_ready,
  input logic [15:0]        gain,
  input logic [13:0]        reduction_db,
  input logic               cfg_wr_en,
  input logic [2:0]         cfg_index,
  input logic [19:0]        cfg_data
);
  import sdg_pkg::*;

  // a waiting result holds its reduction
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(reduction_db))
    else $error("result changed while stalled");

  // busy after a request is taken
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after accept");

  // zero reduction means unity gain
  assert property (@(posedge clk) disable iff (rst)
    out_valid && reduction_db == 14'd0 |-> gain == 16'd32768)
    else $error("gain not unity at zero reduction");

  // gain never above unity
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> gain <= 16'd32768)
    else $error("gain above unity");

  // reset empties the output
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind sidechain_ducker_gain_core sdg_checker u_sdg_checker (.*);
